[hw/rtl/whd_pkg.sv]
// package for the waveform hit detector: constants, payload structs,
// controller/datapath command and status types, state and register codes
// no dependencies
package whd_pkg;

  // sizing
  localparam int MAX_AVERAGE = 16;
  localparam int HIST_DEPTH  = MAX_AVERAGE + 1;
  localparam int TAP_W       = $clog2(HIST_DEPTH);
  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 21;
  localparam int DIV_W       = SUM_W - 1;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic signed [SAMPLE_W-1:0] INIT_MIN = 16'sd9999;
  localparam logic signed [SAMPLE_W-1:0] INIT_MAX = -16'sd9999;

  // register reset values
  localparam logic [4:0]                 AVG_LEN_RST   = 5'd4;
  localparam logic signed [SAMPLE_W-1:0] COMMON_TH_RST = '0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG_LEN   = 2'd0,
    CFG_DROP_LAST = 2'd1,
    CFG_COMMON_TH = 2'd2
  } cfg_idx_t;

  // input item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       first_sample;
    logic                       last_sample;
    logic signed [SAMPLE_W-1:0] channel_threshold;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                       hit;
    logic signed [SAMPLE_W-1:0] min_diff;
    logic signed [SAMPLE_W-1:0] max_diff;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_TRACK_NEW,
    ST_TRACK_OLD,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             sum_add;
    logic             take_old;
    logic             div_step;
    logic             track;
    logic             track_old;
    logic             commit;
    logic [TAP_W-1:0] tap;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             eval_in;
    logic [TAP_W-1:0] len;
    logic             last_pend;
    logic             out_busy;
  } status_t;

endpackage

[hw/rtl/whd_ctrl.sv]
// controller state machine of the waveform hit detector
// sequences window sum, serial divide, min/max tracking and commit
// depends on whd_pkg
module whd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output whd_pkg::cmd_t    cmd,
  input  whd_pkg::status_t stat
);
  import whd_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.tap   = cnt_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = stat.eval_in ? ST_SUM : ST_COMMIT;
        end
      end
      // walk the window taps, then grab the sample just before it
      ST_SUM: begin
        if (cnt_r == stat.len) begin
          cmd.take_old = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end else begin
          cmd.sum_add = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end
      // one quotient bit per cycle
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_TRACK_NEW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TRACK_NEW: begin
        cmd.track = 1'b1;
        state_nxt = ST_TRACK_OLD;
      end
      ST_TRACK_OLD: begin
        cmd.track     = 1'b1;
        cmd.track_old = 1'b1;
        state_nxt     = ST_COMMIT;
      end
      // hold a last sample while the previous result is still waiting
      ST_COMMIT: begin
        if (!(stat.last_pend && stat.out_busy)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/whd_datapath.sv]
// datapath of the waveform hit detector: config registers, sample history,
// window accumulator, restoring divider, min/max trackers and result register
// depends on whd_pkg
module whd_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  whd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output whd_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic [whd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  whd_pkg::cmd_t                  cmd,
  output whd_pkg::status_t               stat
);
  import whd_pkg::*;

  // configuration
  logic [4:0]                 avg_len_r;
  logic                       drop_last_r;
  logic signed [SAMPLE_W-1:0] cth_r;

  // current item
  logic signed [SAMPLE_W-1:0] samp_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] chth_r;

  // channel state
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic signed [SAMPLE_W-1:0] hist_r [HIST_DEPTH];

  // window sum and divider
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic                       neg_r;
  logic [4:0]                 rem_r;
  logic [DIV_W-1:0]           dq_r;

  logic                       out_valid_r;
  out_item_t                  out_r;

  logic [TAP_W-1:0]           len;
  logic [IDX_W-1:0]           idx_eff;
  logic signed [SUM_W-1:0]    acc_neg;
  logic [4:0]                 trial;
  logic                       qbit;
  logic [SAMPLE_W-1:0]        qlow;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [SAMPLE_W-1:0] tsel;
  logic signed [SAMPLE_W-1:0] diff;
  logic signed [SAMPLE_W-1:0] thr;
  logic                       hit;

  // effective average length, 0 acts as 1, clamped to MAX_AVERAGE
  always_comb begin
    if (avg_len_r == '0) begin
      len = TAP_W'(1);
    end else if (avg_len_r > 5'(MAX_AVERAGE)) begin
      len = TAP_W'(MAX_AVERAGE);
    end else begin
      len = TAP_W'(avg_len_r);
    end
  end

  // evaluate decision for the item on the input port
  assign idx_eff = in_data.first_sample ? '0 : idx_r;

  assign stat.eval_in   = (idx_eff >= (IDX_W'(len) + 1'b1)) &&
                          !(in_data.last_sample && drop_last_r);
  assign stat.len       = len;
  assign stat.last_pend = last_r;
  assign stat.out_busy  = out_valid_r && !out_ready;

  // divider step: shift next dividend bit into the remainder
  assign acc_neg = -acc_r;
  assign trial   = {rem_r[3:0], dq_r[DIV_W-1]};
  assign qbit    = (trial >= 5'(len));

  // baseline, truncated toward zero, wrapped to 16 bits
  assign qlow = dq_r[SAMPLE_W-1:0];
  assign base = neg_r ? -$signed(qlow) : $signed(qlow);

  // difference from baseline, wrapped
  assign tsel = cmd.track_old ? old_r : samp_r;
  assign diff = tsel - base;

  // hit decision on the final min and max
  assign thr = (cth_r != '0) ? cth_r : chth_r;
  assign hit = (max_r > thr) || (min_r <= ~thr);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_len_r   <= AVG_LEN_RST;
      drop_last_r <= 1'b0;
      cth_r       <= COMMON_TH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AVG_LEN:   avg_len_r   <= cfg_data[4:0];
        CFG_DROP_LAST: drop_last_r <= cfg_data[0];
        CFG_COMMON_TH: cth_r       <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // channel control state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      min_r       <= INIT_MIN;
      max_r       <= INIT_MAX;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (cmd.commit && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load && in_data.first_sample) begin
        idx_r <= '0;
        min_r <= INIT_MIN;
        max_r <= INIT_MAX;
      end
      if (cmd.track) begin
        if (diff < min_r) begin
          min_r <= diff;
        end
        if (diff > max_r) begin
          max_r <= diff;
        end
      end
      if (cmd.commit) begin
        if (last_r) begin
          idx_r <= '0;
          min_r <= INIT_MIN;
          max_r <= INIT_MAX;
        end else if (idx_r < IDX_W'(MAX_SAMPLES)) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // payload: item latch, window sum, divider, history, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_r <= in_data.sample_value;
      last_r <= in_data.last_sample;
      chth_r <= in_data.channel_threshold;
      acc_r  <= '0;
    end
    if (cmd.sum_add) begin
      acc_r <= acc_r + SUM_W'(hist_r[cmd.tap]);
    end
    if (cmd.take_old) begin
      old_r <= hist_r[cmd.tap];
      neg_r <= acc_r[SUM_W-1];
      rem_r <= '0;
      dq_r  <= acc_r[SUM_W-1] ? acc_neg[DIV_W-1:0] : acc_r[DIV_W-1:0];
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? (trial - 5'(len)) : trial;
      dq_r  <= {dq_r[DIV_W-2:0], qbit};
    end
    if (cmd.commit) begin
      hist_r[0] <= samp_r;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      if (last_r) begin
        out_r.hit      <= hit;
        out_r.min_diff <= min_r;
        out_r.max_diff <= max_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/waveform_hit_detector_core.sv]
// waveform hit detector top level: controller plus datapath
// one item at a time; an evaluated sample goes through accept, the sum over L
// window taps and the older sample (L = effective average length), the divide,
// tracking and commit; others go accept to commit; result valid the cycle after commit
// synchronous active-low reset restores register defaults and clears channel state
module waveform_hit_detector_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  whd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output whd_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [whd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [whd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import whd_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencing
  whd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // arithmetic and storage
  whd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTHESIS
  // one item at a time: busy right after a transfer
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a result only comes from committing a last sample
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit && stat.last_pend))
    else $error("result without a committed last sample");

  // min and max are either untouched or ordered
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.min_diff <= out_data.max_diff) ||
                   (out_data.min_diff == INIT_MIN && out_data.max_diff == INIT_MAX)))
    else $error("inconsistent min/max in result");
`endif

endmodule
